// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define UTRD_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define UTRD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/utrd_pkg.sv =====
`timescale 1ns / 1ps

package utrd_pkg;

    localparam int STEP_BITS      = 8;   // dividend bits retired per divider cycle
    localparam int DIGIT_BITS     = 4;
    localparam int CHAR_BITS      = 7;
    localparam int RADIX_MIN      = 2;
    localparam int RADIX_MAX      = 16;
    localparam int RADIX_BITS     = 5;
    localparam int CODE_ZERO      = 48;
    localparam int CODE_LETTER_A  = 65;
    localparam int IN_VALUE_BITS  = 64;
    localparam int IN_BASE_BITS   = 8;
    localparam int IN_TDATA_BITS  = 72;
    localparam int OUT_TDATA_BITS = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD,
        S_INV
    } t_state;

    typedef struct packed {
        logic load;        // latch value and base from the input item
        logic div;         // one divider cycle
        logic out_digit;   // load a digit into the output register
        logic out_inv;     // load the invalid-base result
    } t_cmd;

    typedef struct packed {
        logic base_ok;     // input base within 2..16
        logic div_done;    // this divider cycle stores the final digit
        logic rd_last;     // read pointer at the least significant digit
        logic out_free;    // output register can take a new item
    } t_stat;

    function automatic logic [CHAR_BITS-1:0] digit_code(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DIGIT_BITS'(10)) begin
            c = CHAR_BITS'(CODE_ZERO) + CHAR_BITS'(d);
        end else begin
            c = CHAR_BITS'(CODE_LETTER_A) + CHAR_BITS'(d) - CHAR_BITS'(10);
        end
        return c;
    endfunction

endpackage

// ===== src/unsigned_to_radix_digits.sv =====
`timescale 1ns / 1ps

// Converts an unsigned number to ASCII digits ('0'-'9', 'A'-'F') in base 2..16.
// Slave channel: one item = value and base. Master channel: one item per digit,
// most significant digit first, tlast on the final digit. A zero value gives '0'.
// A base outside 2..16 gives a single item with tuser set, tlast set, data 0.
// Each digit is one pass of the divider, which retires 8 dividend bits per cycle
// against the 4-bit remainder; digits go to a MAX_DIGITS x 4 store. Emission
// reads each digit from the store, then loads it into the output register.
// One item is converted at a time: s_tready is high only when the previous
// item's digits have all entered the output register. The output register holds
// its item while m_tready is low; the block waits and drops nothing.
// Reset (synchronous, active low) returns to idle and clears the output valid.
module unsigned_to_radix_digits
    import utrd_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [IN_TDATA_BITS-1:0]  i_s_tdata,   // [63:0] value, [71:64] base
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_tdata,   // [6:0] digit_char, [7] zero
    output logic                      o_m_tlast,
    output logic                      o_m_tuser    // [0] invalid_base
);

    t_cmd  cmd;
    t_stat stat;

    utrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    utrd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== src/utrd_ram.sv =====
`timescale 1ns / 1ps

module utrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/utrd_ctrl.sv =====
`timescale 1ns / 1ps

module utrd_ctrl
    import utrd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  t_stat i_stat,
    output logic  o_s_tready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_stat.base_ok ? S_DIV : S_INV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.rd_last ? S_IDLE : S_READ;
                end
            end
            S_INV: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
            end
            S_LOAD: begin
                o_cmd.out_digit = i_stat.out_free;
            end
            S_INV: begin
                o_cmd.out_inv = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/utrd_dp.sv =====
`timescale 1ns / 1ps

module utrd_dp
    import utrd_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [IN_TDATA_BITS-1:0]  i_s_tdata,
    input  logic                      i_m_tready,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    output logic                      o_m_tvalid,
    output logic [OUT_TDATA_BITS-1:0] o_m_tdata,
    output logic                      o_m_tlast,
    output logic                      o_m_tuser
);

    localparam int W_PAD  = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int CHUNKS = W_PAD / STEP_BITS;
    localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int CNTW   = $clog2(MAX_DIGITS + 1);

    logic [W_PAD-1:0]      r_quo;
    logic [W_PAD-1:0]      n_quo;
    logic [DIGIT_BITS-1:0] r_rem;
    logic [DIGIT_BITS-1:0] n_rem;
    logic [RADIX_BITS-1:0] r_base;
    logic [CHW-1:0]        r_chunk;
    logic [CNTW-1:0]       r_cnt;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_digit;
    logic                  r_last;
    logic                  r_inv;

    logic [STEP_BITS-1:0]  q_bits;
    logic                  chunk_last;
    logic                  cnt_last;
    logic                  out_free;
    logic                  wr_en;
    logic [DIGIT_BITS-1:0] rd_data;
    logic [IN_BASE_BITS-1:0] base_in;
    logic [W_PAD-1:0]      value_in;

    assign base_in    = i_s_tdata[IN_VALUE_BITS +: IN_BASE_BITS];
    assign chunk_last = (r_chunk == CHW'(CHUNKS - 1));
    assign cnt_last   = (r_cnt == CNTW'(MAX_DIGITS - 1));
    assign out_free   = !r_out_valid || i_m_tready;
    assign wr_en      = i_cmd.div && chunk_last;

    always_comb begin
        value_in = '0;
        value_in[VALUE_WIDTH-1:0] = i_s_tdata[VALUE_WIDTH-1:0];
    end

    // Restoring division by the base, STEP_BITS dividend bits per cycle, MSB first.
    always_comb begin
        logic [RADIX_BITS-1:0] t;
        logic [RADIX_BITS-1:0] rem_t;
        rem_t  = {1'b0, r_rem};
        q_bits = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            t = {rem_t[DIGIT_BITS-1:0], r_quo[W_PAD-1-i]};
            if (t >= r_base) begin
                q_bits[STEP_BITS-1-i] = 1'b1;
                rem_t = t - r_base;
            end else begin
                rem_t = t;
            end
        end
        n_rem = rem_t[DIGIT_BITS-1:0];
        n_quo = (r_quo << STEP_BITS) | W_PAD'(q_bits);
    end

    assign o_stat.base_ok  = (base_in >= IN_BASE_BITS'(RADIX_MIN)) &&
                             (base_in <= IN_BASE_BITS'(RADIX_MAX));
    assign o_stat.div_done = wr_en && ((n_quo == '0) || cnt_last);
    assign o_stat.rd_last  = (r_rd_idx == '0);
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_quo   <= value_in;
                r_base  <= base_in[RADIX_BITS-1:0];
                r_rem   <= '0;
                r_chunk <= '0;
                r_cnt   <= '0;
            end else if (i_cmd.div) begin
                r_quo <= n_quo;
                if (chunk_last) begin
                    // remainder complete: it is the next digit, start the next pass
                    r_rem   <= '0;
                    r_chunk <= '0;
                    r_cnt   <= r_cnt + CNTW'(1);
                    if (o_stat.div_done) begin
                        r_rd_idx <= r_cnt[AW-1:0];
                    end
                end else begin
                    r_rem   <= n_rem;
                    r_chunk <= r_chunk + CHW'(1);
                end
            end

            if (i_cmd.out_digit) begin
                r_digit  <= digit_code(rd_data);
                r_last   <= o_stat.rd_last;
                r_inv    <= 1'b0;
                r_rd_idx <= r_rd_idx - AW'(1);
            end else if (i_cmd.out_inv) begin
                r_digit <= '0;
                r_last  <= 1'b1;
                r_inv   <= 1'b1;
            end

            if (i_cmd.out_digit || i_cmd.out_inv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    utrd_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (n_rem),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_BITS - CHAR_BITS){1'b0}}, r_digit};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_inv;

endmodule

// ===== src/utrd_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utrd_chk
    import utrd_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [OUT_TDATA_BITS-1:0] o_m_tdata,
    input logic                      o_m_tlast,
    input logic                      o_m_tuser
);

    // invalid-base item is a lone terminal item with no character
    `UTRD_ASSERT_NOW(a_inv_shape, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast && (o_m_tdata == '0), "invalid-base item malformed")

    // digits are only legal ASCII codes
    `UTRD_ASSERT_NOW(a_digit_code, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, ((o_m_tdata >= OUT_TDATA_BITS'(CODE_ZERO)) && (o_m_tdata <= OUT_TDATA_BITS'(CODE_ZERO + 9))) || ((o_m_tdata >= OUT_TDATA_BITS'(CODE_LETTER_A)) && (o_m_tdata <= OUT_TDATA_BITS'(CODE_LETTER_A + 5))), "digit code out of range")

    // one conversion at a time: an accept closes the slave side
    `UTRD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_rst_n && i_s_tvalid && o_s_tready, !o_s_tready, "input accepted while converting")

    // a stalled item is held
    `UTRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_rst_n && o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser), "stalled output item changed")

endmodule

bind unsigned_to_radix_digits utrd_chk u_chk (.*);

// ===== verif/unsigned_to_radix_digits_test.sv =====
`timescale 1ns / 1ps

module unsigned_to_radix_digits_test;
    import utrd_pkg::*;

    localparam int     DIGITS_MAX    = 64;
    localparam int     DIRECTED_ROWS = 22;
    localparam int     RANDOM_ITEMS  = 360;
    localparam int     CALM_ITEMS    = 40;
    localparam int     LONG_HOLD     = 1500;
    localparam int     DRAIN_CYCLES  = 700;
    localparam longint CYCLE_LIMIT   = 3_000_000;

    typedef logic [CHAR_BITS-1:0] char_t;

    localparam char_t CH_0 = char_t'(CODE_ZERO);
    localparam char_t CH_1 = CH_0 + char_t'(1);
    localparam char_t CH_9 = CH_0 + char_t'(9);
    localparam char_t CH_A = char_t'(CODE_LETTER_A);
    localparam char_t CH_F = CH_A + char_t'(5);

    typedef struct packed {
        char_t ch;
        logic  last;
        logic  inv;
    } digit_result_t;

    typedef struct {
        logic [63:0] value;
        logic [7:0]  base;
        bit          typed;   // expected single result given in the row
        char_t       ch;
        logic        inv;
    } stim_row_t;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      m_tready = 1'b0;
    logic                      o_s_tready;
    logic                      o_m_tvalid;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;
    logic                      o_m_tlast;
    logic                      o_m_tuser;

    digit_result_t expected_digits[$];
    stim_row_t     directed [DIRECTED_ROWS];
    int            errors = 0;
    bit            calm = 1'b0;
    longint        cycles = 0;

    unsigned_to_radix_digits u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // [63:0] value, [71:64] base
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),   // [6:0] digit_char, [7] zero
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)    // [0] invalid_base
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Repeated division, remainders kept LSD first, queued MSD first.
    function automatic void predict_conversion(input logic [63:0] value,
                                               input logic [7:0] base);
        logic [63:0]   q;
        logic [3:0]    rems [DIGITS_MAX];
        int            n;
        digit_result_t r;
        if (base < RADIX_MIN || base > RADIX_MAX) begin
            r = '{ch: '0, last: 1'b1, inv: 1'b1};
            expected_digits.push_back(r);
            return;
        end
        q = value;
        n = 0;
        if (q == 0) begin
            rems[0] = 4'd0;
            n = 1;
        end else begin
            while (q != 0 && n < DIGITS_MAX) begin
                rems[n] = 4'(q % base);
                q = q / base;
                n++;
            end
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (rems[k] < 4'd10) begin
                r.ch = CH_0 + char_t'(rems[k]);
            end else begin
                r.ch = CH_A + char_t'(rems[k]) - char_t'(10);
            end
            r.last = (k == 0);
            r.inv  = 1'b0;
            expected_digits.push_back(r);
        end
    endfunction

    task automatic send_item(input logic [63:0] value, input logic [7:0] base);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {base, value};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0]   v;
        logic [7:0]    b;
        digit_result_t r;
        directed = '{
            '{64'd0,                  8'd10,  1'b1, CH_0, 1'b0},
            '{64'd0,                  8'd2,   1'b1, CH_0, 1'b0},
            '{64'd0,                  8'd16,  1'b1, CH_0, 1'b0},
            '{64'd1,                  8'd2,   1'b1, CH_1, 1'b0},
            '{64'd15,                 8'd16,  1'b1, CH_F, 1'b0},
            '{64'd10,                 8'd16,  1'b1, CH_A, 1'b0},
            '{64'd9,                  8'd10,  1'b1, CH_9, 1'b0},
            '{64'd42,                 8'd0,   1'b1, '0,   1'b1},
            '{64'd42,                 8'd1,   1'b1, '0,   1'b1},
            '{64'd42,                 8'd17,  1'b1, '0,   1'b1},
            '{64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, '0,   1'b1},
            '{64'd0,                  8'h80,  1'b1, '0,   1'b1},
            '{64'd0,                  8'd0,   1'b1, '0,   1'b1},
            '{64'hFFFF_FFFF_FFFF_FFFF, 8'd2,  1'b0, '0,   1'b0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 8'd16, 1'b0, '0,   1'b0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 8'd3,  1'b0, '0,   1'b0},
            '{64'hFFFF_FFFF_FFFF_FFFF, 8'd10, 1'b0, '0,   1'b0},
            '{64'h8000_0000_0000_0000, 8'd2,  1'b0, '0,   1'b0},
            '{64'hFEDC_BA98_7654_3210, 8'd16, 1'b0, '0,   1'b0},
            '{64'd16,                 8'd16,  1'b0, '0,   1'b0},
            '{64'd255,                8'd15,  1'b0, '0,   1'b0},
            '{64'h0123_4567_89AB_CDEF, 8'd7,  1'b0, '0,   1'b0}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_item(directed[i].value, directed[i].base);
            if (directed[i].typed) begin
                r = '{ch: directed[i].ch, last: 1'b1, inv: directed[i].inv};
                expected_digits.push_back(r);
            end else begin
                predict_conversion(directed[i].value, directed[i].base);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
            // a random right shift spreads the value widths, with an occasional zero
            if ($urandom_range(0, 29) == 0) begin
                v = '0;
            end else begin
                v = {$urandom, $urandom};
                v = v >> $urandom_range(0, 63);
            end
            if ($urandom_range(0, 6) == 0) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = 8'($urandom_range(RADIX_MIN, RADIX_MAX));
            end
            send_item(v, b);
            predict_conversion(v, b);
        end
        s_tvalid <= 1'b0;

        while (expected_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Output side: check each accepted item, then pick tready for the next cycle.
    initial begin
        int            stall_left = 0;
        int            digits_seen = 0;
        bit            held = 1'b0;
        digit_result_t exp_d;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && m_tready) begin
                digits_seen++;
                if (expected_digits.size() == 0) begin
                    $error("unexpected item: digit_char %0d last %0b invalid_base %0b",
                           o_m_tdata[CHAR_BITS-1:0], o_m_tlast, o_m_tuser);
                    errors++;
                end else begin
                    exp_d = expected_digits.pop_front();
                    if (o_m_tdata[CHAR_BITS-1:0] !== exp_d.ch) begin
                        $error("digit_char: expected %0d, got %0d",
                               exp_d.ch, o_m_tdata[CHAR_BITS-1:0]);
                        errors++;
                    end
                    if (o_m_tdata[OUT_TDATA_BITS-1] !== 1'b0) begin
                        $error("tdata pad: expected 0, got %0b", o_m_tdata[OUT_TDATA_BITS-1]);
                        errors++;
                    end
                    if (o_m_tlast !== exp_d.last) begin
                        $error("last: expected %0b, got %0b", exp_d.last, o_m_tlast);
                        errors++;
                    end
                    if (o_m_tuser !== exp_d.inv) begin
                        $error("invalid_base: expected %0b, got %0b", exp_d.inv, o_m_tuser);
                        errors++;
                    end
                end
            end
            // one long hold so the block backs up onto its input
            if (!held && digits_seen >= 400) begin
                held = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
